### hdl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants for the clustered hash table
// Entry layout, operation codes, register indexes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int ENTRY_W = 80;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  depth;
    logic [7:0]  genbound;
    logic [15:0] move;
    logic [15:0] value;
    logic [15:0] eval;
  } entry_t;

  localparam logic [2:0] KIND_PROBE = 3'd0;
  localparam logic [2:0] KIND_STORE = 3'd1;
  localparam logic [2:0] KIND_NEWS  = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_OCC   = 3'd4;

  localparam int         CFG_IDX_W = 2;
  localparam logic [1:0] CFG_DOFF  = 2'd0;
  localparam logic [1:0] CFG_NONE  = 2'd1;

  localparam logic [3:0]  DOFF_RST  = 4'hD;
  localparam logic [15:0] NONE_RST  = 16'd32002;
  localparam logic [1:0]  BND_EXACT = 2'd3;
  localparam logic [7:0]  GEN_STEP  = 8'd8;
  localparam logic [7:0]  AGE_BIAS  = 8'd7;   // 263 modulo 256
  localparam logic [7:0]  AGE_MASK  = 8'hF8;
  localparam int          PERMILLE  = 1000;
  localparam int          QUOT_W    = 10;

  typedef struct packed {
    logic latch;
    logic gen_add;
    logic gen_clr;
    logic sw_init;
    logic clr_step;
    logic mul_lo;
    logic mul_hi;
    logic rd_probe;
    logic rd_store;
    logic wr_store;
    logic occ_step;
    logic occ_mul;
    logic div_step;
    logic res_probe;
    logic res_zero;
    logic res_occ;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic occ_last;
  } sts_t;

  function automatic logic [7:0] age_f(input logic [7:0] gen, input logic [7:0] gb);
    age_f = (AGE_BIAS + gen - gb) & AGE_MASK;
  endfunction

endpackage

### hdl/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl: operation sequencer
// One-hot state machine that steps the datapath through probe, store,
// new search, clear and occupancy operations.
// ----------------------------------------------------------------------------
module cht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        kind,
  output logic              busy,
  output cht_pkg::cmd_t     cmd,
  input  cht_pkg::sts_t     sts
);

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_MLO  = 12'b000000000100,
    S_MHI  = 12'b000000001000,
    S_RD   = 12'b000000010000,
    S_EVAL = 12'b000000100000,
    S_FIN  = 12'b000001000000,
    S_OSWP = 12'b000010000000,
    S_ODRN = 12'b000100000000,
    S_OMUL = 12'b001000000000,
    S_DIV  = 12'b010000000000,
    S_OOUT = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   is_store, is_store_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      is_store <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      is_store <= is_store_next;
      pend     <= pend_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    is_store_next = is_store;
    pend_next     = pend;
    cmd           = '0;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          pend_next  = 1'b0;
          state_next = pend ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch     = 1'b1;
          is_store_next = (kind == cht_pkg::KIND_STORE);
          case (kind)
            cht_pkg::KIND_PROBE: state_next = S_MLO;
            cht_pkg::KIND_STORE: state_next = S_RD;
            cht_pkg::KIND_NEWS: begin
              cmd.gen_add = 1'b1;
              state_next  = S_FIN;
            end
            cht_pkg::KIND_CLEAR: begin
              cmd.gen_clr = 1'b1;
              cmd.sw_init = 1'b1;
              pend_next   = 1'b1;
              state_next  = S_CLR;
            end
            cht_pkg::KIND_OCC: begin
              cmd.sw_init = 1'b1;
              state_next  = S_OSWP;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_store = is_store;
        cmd.rd_probe = !is_store;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        cmd.wr_store  = is_store;
        cmd.res_zero  = is_store;
        cmd.res_probe = !is_store;
        state_next    = S_IDLE;
      end
      S_FIN: begin
        cmd.res_zero = 1'b1;
        state_next   = S_IDLE;
      end
      S_OSWP: begin
        cmd.occ_step = 1'b1;
        if (sts.occ_last) state_next = S_ODRN;
      end
      S_ODRN: state_next = S_OMUL;   // last row lands in the count here
      S_OMUL: begin
        cmd.occ_mul = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_OOUT;
      end
      S_OOUT: begin
        cmd.res_occ = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && state == S_IDLE) |=> (state != S_IDLE))
    else $error("accepted beat did not start an operation");

  a_occ_out_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_OOUT) |-> $past(state == S_DIV))
    else $error("occupancy result without a finished division");
`endif

endmodule

### hdl/cht_dp.sv
// ----------------------------------------------------------------------------
// cht_dp: table datapath
// Entry memory (one row per cluster), cluster hash multiply, probe and
// store evaluation, occupancy count and per mille scaling.
// ----------------------------------------------------------------------------
module cht_dp #(
  parameter int NUM_CLUSTERS    = 1024,
  parameter int WAYS            = 3,
  parameter int SAMPLE_CLUSTERS = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cht_pkg::cmd_t                 cmd,
  output cht_pkg::sts_t                 sts,
  input  logic                          cfg_we,
  input  logic [cht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic [63:0]                   key,
  input  logic signed [15:0]            value,
  input  logic signed [15:0]            eval,
  input  logic signed [8:0]             depth,
  input  logic [1:0]                    bound,
  input  logic                          pv,
  input  logic [15:0]                   best_move,
  input  logic [9:0]                    target_cluster,
  input  logic [1:0]                    target_way,
  input  logic [4:0]                    max_age,
  output logic                          done,
  output logic                          found,
  output logic [15:0]                   out_move,
  output logic signed [15:0]            out_value,
  output logic signed [15:0]            out_eval,
  output logic signed [8:0]             out_depth,
  output logic [1:0]                    out_bound,
  output logic                          out_pv,
  output logic [9:0]                    slot_cluster,
  output logic [1:0]                    slot_way,
  output logic [9:0]                    occupancy
);

  localparam int EW    = cht_pkg::ENTRY_W;
  localparam int ROW_W = WAYS * EW;
  localparam int CLW   = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int NW    = $clog2(NUM_CLUSTERS + 1);
  localparam int PLW   = 32 + NW;
  localparam int CXW   = 21;
  localparam int SWW   = $clog2(NUM_CLUSTERS + 1);
  localparam int NSAMP = (SAMPLE_CLUSTERS < NUM_CLUSTERS) ? SAMPLE_CLUSTERS : NUM_CLUSTERS;
  localparam int DIVS  = NSAMP * WAYS;
  localparam int CNT_W = $clog2(DIVS + 1);
  localparam int PW    = CNT_W + 10;
  localparam int SH    = PW + CNT_W;
  localparam int RW    = PW + 2;
  localparam int WW    = 4;
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(DIVS) - 1) / longint'(DIVS);
  localparam logic [RW-1:0]  RECIP   = RW'(RECIP_L);
  localparam logic [PLW-1:0] NC_L    = PLW'(NUM_CLUSTERS);
  localparam logic [SWW-1:0] CLR_END = SWW'(NUM_CLUSTERS - 1);
  localparam logic [SWW-1:0] OCC_END = SWW'(NSAMP - 1);

  // configuration and generation
  logic [3:0]  doff;
  logic [15:0] nonev;
  logic [7:0]  gen;

  // latched item
  logic [63:0]        k_key;
  logic signed [15:0] k_value, k_eval;
  logic signed [8:0]  k_depth;
  logic [1:0]         k_bound;
  logic               k_pv;
  logic [15:0]        k_move;
  logic [9:0]         k_tc;
  logic [1:0]         k_tw;
  logic [4:0]         k_max_age;

  logic [PLW-1:0] p_lo, p_hi;
  logic [PLW:0]   hi_sum;
  logic [CLW-1:0] clus;
  logic [SWW-1:0] sw;
  logic [ROW_W-1:0] rd_data;
  logic             rd_occ_q;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    rem;
  logic [PW+RW-1:0] prod;
  logic [cht_pkg::QUOT_W-1:0] quot;

  logic [ROW_W-1:0] mem [NUM_CLUSTERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      doff  <= cht_pkg::DOFF_RST;
      nonev <= cht_pkg::NONE_RST;
    end else if (cfg_we) begin
      if (cfg_index == cht_pkg::CFG_DOFF) doff  <= cfg_data[3:0];
      if (cfg_index == cht_pkg::CFG_NONE) nonev <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= '0;
    end else if (cmd.gen_clr) begin
      gen <= '0;
    end else if (cmd.gen_add) begin
      gen <= gen + cht_pkg::GEN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      k_key     <= key;
      k_value   <= value;
      k_eval    <= eval;
      k_depth   <= depth;
      k_bound   <= bound;
      k_pv      <= pv;
      k_move    <= best_move;
      k_tc      <= target_cluster;
      k_tw      <= target_way;
      k_max_age <= max_age;
    end
  end

  // cluster = floor(key * NUM_CLUSTERS / 2^64), one half product per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) p_lo <= PLW'(k_key[31:0]) * NC_L;
    if (cmd.mul_hi) p_hi <= PLW'(k_key[63:32]) * NC_L;
  end
  assign hi_sum = (PLW + 1)'(p_hi) + (PLW + 1)'(p_lo[PLW-1:32]);

  logic [CXW-1:0] tc_ext;
  logic           store_ok;
  assign tc_ext   = CXW'(k_tc);
  assign store_ok = (tc_ext < CXW'(NUM_CLUSTERS)) && (WW'(k_tw) < WW'(WAYS));

  // memory ports
  logic           re, we;
  logic [CLW-1:0] ra, wa;
  logic [ROW_W-1:0] wd, new_row;

  always_comb begin
    re = cmd.rd_probe | cmd.rd_store | cmd.occ_step;
    ra = sw[CLW-1:0];
    if (cmd.rd_probe) ra = hi_sum[32 +: CLW];
    if (cmd.rd_store) ra = tc_ext[CLW-1:0];
    we = cmd.clr_step | (cmd.wr_store & store_ok);
    wa = cmd.clr_step ? sw[CLW-1:0] : clus;
    wd = cmd.clr_step ? '0 : new_row;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_probe || cmd.rd_store) clus <= ra;
  end

  // sweep counter for clearing and occupancy
  always_ff @(posedge clk) begin
    if (rst || cmd.sw_init) begin
      sw <= '0;
    end else if (cmd.clr_step || cmd.occ_step) begin
      sw <= sw + SWW'(1);
    end
  end
  assign sts.clr_last = (sw == CLR_END);
  assign sts.occ_last = (sw == OCC_END);

  // split the row into ways
  cht_pkg::entry_t ways_e [WAYS];
  logic [7:0]      ages   [WAYS];
  logic signed [10:0] score [WAYS];
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ways_e[w] = cht_pkg::entry_t'(rd_data[w*EW +: EW]);
      ages[w]   = cht_pkg::age_f(gen, ways_e[w].genbound);
      score[w]  = $signed({3'd0, ways_e[w].depth}) - $signed({2'd0, ages[w], 1'b0});
    end
  end

  // probe: first matching tag, else first way with least depth - 2*age
  logic            hit;
  cht_pkg::entry_t hit_e;
  logic [WW-1:0]   hit_w, best_w;
  logic signed [10:0] best_s;
  always_comb begin
    hit    = 1'b0;
    hit_e  = '0;
    hit_w  = '0;
    best_w = '0;
    best_s = score[0];
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && ways_e[w].tag == k_key[15:0]) begin
        hit   = 1'b1;
        hit_e = ways_e[w];
        hit_w = WW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (best_s > score[w]) begin
        best_s = score[w];
        best_w = WW'(w);
      end
    end
  end

  // store: replacement rules on the target way
  cht_pkg::entry_t old_e, new_e;
  logic               tag_diff, deeper, keep_rest;
  logic signed [11:0] d_adj, lhs, rhs;
  always_comb begin
    old_e = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) == WW'(k_tw)) old_e = ways_e[w];
    end
    tag_diff  = (old_e.tag != k_key[15:0]);
    d_adj     = 12'(k_depth) - 12'($signed(doff));
    lhs       = d_adj + $signed({10'd0, k_pv, 1'b0});
    rhs       = $signed({4'd0, old_e.depth}) - 12'sd4;
    deeper    = (lhs > rhs);
    keep_rest = !((k_bound == cht_pkg::BND_EXACT) || tag_diff || deeper ||
                  (cht_pkg::age_f(gen, old_e.genbound) != 8'd0));
    new_e      = old_e;
    if ((k_move != 16'd0) || tag_diff) new_e.move = k_move;
    if (!keep_rest) begin
      new_e.tag      = k_key[15:0];
      new_e.depth    = d_adj[7:0];
      new_e.genbound = gen | {5'd0, k_pv, k_bound};
      new_e.value    = k_value;
      new_e.eval     = k_eval;
    end
    new_row = rd_data;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) == WW'(k_tw)) new_row[w*EW +: EW] = new_e;
    end
  end

  // occupancy: count fresh occupied entries a row per cycle
  logic [7:0]    limit;
  logic [WW:0]   row_cnt;
  always_comb begin
    limit   = {k_max_age, 3'd0};
    row_cnt = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (ways_e[w].depth != 8'd0 && ages[w] <= limit) row_cnt = row_cnt + (WW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_occ_q <= 1'b0;
    end else begin
      rd_occ_q <= cmd.occ_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_init) begin
      cnt <= '0;
    end else if (rd_occ_q) begin
      cnt <= cnt + CNT_W'(row_cnt);
    end
  end

  // count*1000 over sampled entries: multiply by the reciprocal rounded up;
  // the extra fraction bits keep the top of the product the exact quotient
  always_ff @(posedge clk) begin
    if (cmd.occ_mul) rem <= PW'(cnt) * PW'(cht_pkg::PERMILLE);
    if (cmd.div_step) prod <= (PW + RW)'(rem) * (PW + RW)'(RECIP);
  end
  assign quot = prod[SH +: cht_pkg::QUOT_W];

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_probe | cmd.res_zero | cmd.res_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero || cmd.res_occ) begin
      found        <= 1'b0;
      out_move     <= '0;
      out_value    <= '0;
      out_eval     <= '0;
      out_depth    <= '0;
      out_bound    <= '0;
      out_pv       <= 1'b0;
      slot_cluster <= '0;
      slot_way     <= '0;
      occupancy    <= cmd.res_occ ? quot : '0;
    end else if (cmd.res_probe) begin
      slot_cluster <= 10'(clus);
      occupancy    <= '0;
      if (hit) begin
        found     <= (hit_e.depth != 8'd0);
        out_move  <= hit_e.move;
        out_value <= hit_e.value;
        out_eval  <= hit_e.eval;
        out_depth <= 9'({1'b0, hit_e.depth}) + 9'($signed(doff));
        out_bound <= hit_e.genbound[1:0];
        out_pv    <= hit_e.genbound[2];
        slot_way  <= 2'(hit_w);
      end else begin
        found     <= 1'b0;
        out_move  <= '0;
        out_value <= nonev;
        out_eval  <= nonev;
        out_depth <= 9'($signed(doff));
        out_bound <= '0;
        out_pv    <= 1'b0;
        slot_way  <= 2'(best_w);
      end
    end
  end

`ifndef SYNTHESIS
  a_occ_permille: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= 10'd1000))
    else $error("occupancy above 1000 per mille");
`endif

endmodule

### hdl/clustered_hash_table_with_aging.sv
// ----------------------------------------------------------------------------
// clustered_hash_table_with_aging: set-associative search entry table
// Probe, store, new search, clear and occupancy over a clustered table
// with generation aging.
//
//   channel   handshake             payload
//   command   start / busy          kind, key, value, eval, depth, bound, pv,
//                                   best_move, target_cluster, target_way, max_age
//   result    done (one cycle)      found, out_*, slot_cluster, slot_way, occupancy
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Steps from accept to result: probe makes two half products of the cluster
// multiply, one row read and one evaluate; store a row read and a row rewrite;
// new search and reserved kinds a finishing state; clear zeroes NUM_CLUSTERS
// rows, one a cycle; occupancy counts min(SAMPLE_CLUSTERS,NUM_CLUSTERS) rows,
// one a cycle, then scales by 1000 and multiplies by the reciprocal. After
// reset busy stays high while the store is zeroed. The receiver cannot stall;
// a new command may be taken in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module clustered_hash_table_with_aging #(
  parameter int NUM_CLUSTERS    = 1024,
  parameter int WAYS            = 3,
  parameter int SAMPLE_CLUSTERS = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [63:0]                   key,
  input  logic signed [15:0]            value,
  input  logic signed [15:0]            eval,
  input  logic signed [8:0]             depth,
  input  logic [1:0]                    bound,
  input  logic                          pv,
  input  logic [15:0]                   best_move,
  input  logic [9:0]                    target_cluster,
  input  logic [1:0]                    target_way,
  input  logic [4:0]                    max_age,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [15:0]                   out_move,
  output logic signed [15:0]            out_value,
  output logic signed [15:0]            out_eval,
  output logic signed [8:0]             out_depth,
  output logic [1:0]                    out_bound,
  output logic                          out_pv,
  output logic [9:0]                    slot_cluster,
  output logic [1:0]                    slot_way,
  output logic [9:0]                    occupancy
);

  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  cht_dp #(
    .NUM_CLUSTERS    (NUM_CLUSTERS),
    .WAYS            (WAYS),
    .SAMPLE_CLUSTERS (SAMPLE_CLUSTERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .key            (key),
    .value          (value),
    .eval           (eval),
    .depth          (depth),
    .bound          (bound),
    .pv             (pv),
    .best_move      (best_move),
    .target_cluster (target_cluster),
    .target_way     (target_way),
    .max_age        (max_age),
    .done           (done),
    .found          (found),
    .out_move       (out_move),
    .out_value      (out_value),
    .out_eval       (out_eval),
    .out_depth      (out_depth),
    .out_bound      (out_bound),
    .out_pv         (out_pv),
    .slot_cluster   (slot_cluster),
    .slot_way       (slot_way),
    .occupancy      (occupancy)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an operation in flight");
`endif

endmodule

### test/cht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_checker: scoreboard for the clustered hash table
// Tracks accepted commands and register writes, keeps its own copy of the
// entry table and generation, and compares each done beat with the oldest
// predicted answer.
// ----------------------------------------------------------------------------
module cht_checker #(
  parameter int NUM_CLUSTERS    = 1024,
  parameter int WAYS            = 3,
  parameter int SAMPLE_CLUSTERS = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    kind,
  input  logic [63:0]                   key,
  input  logic signed [15:0]            value,
  input  logic signed [15:0]            eval,
  input  logic signed [8:0]             depth,
  input  logic [1:0]                    bound,
  input  logic                          pv,
  input  logic [15:0]                   best_move,
  input  logic [9:0]                    target_cluster,
  input  logic [1:0]                    target_way,
  input  logic [4:0]                    max_age,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          done,
  input  logic                          found,
  input  logic [15:0]                   out_move,
  input  logic signed [15:0]            out_value,
  input  logic signed [15:0]            out_eval,
  input  logic signed [8:0]             out_depth,
  input  logic [1:0]                    out_bound,
  input  logic                          out_pv,
  input  logic [9:0]                    slot_cluster,
  input  logic [1:0]                    slot_way,
  input  logic [9:0]                    occupancy,
  output int                            fail_count,
  output int                            waiting
);

  localparam int NENT = NUM_CLUSTERS * WAYS;
  localparam int NSAMP = (SAMPLE_CLUSTERS < NUM_CLUSTERS) ? SAMPLE_CLUSTERS : NUM_CLUSTERS;

  typedef struct packed {
    logic        found;
    logic [15:0] mv;
    logic [15:0] val;
    logic [15:0] ev;
    logic [8:0]  dep;
    logic [1:0]  bnd;
    logic        pvf;
    logic [9:0]  cl;
    logic [1:0]  way;
    logic [9:0]  occ;
  } answer_t;

  cht_pkg::entry_t table_q [NENT];
  logic [7:0] gen_q;
  logic [3:0] doff_q;
  logic [15:0] none_q;
  answer_t    answers[$];

  function automatic logic [7:0] entry_age(input logic [7:0] gb);
    logic [7:0] a;
    a = 8'd7 + gen_q - gb;
    return a & 8'hF8;
  endfunction

  function automatic answer_t lookup(input logic [63:0] k);
    answer_t a;
    logic [63:0] lo, hi;
    int c, base, best, bestv, v, off;
    a = '0;
    off = $signed(doff_q);
    lo = 64'(k[31:0]) * 64'(NUM_CLUSTERS);
    hi = 64'(k[63:32]) * 64'(NUM_CLUSTERS) + (lo >> 32);
    c = int'(hi[63:32]);
    a.cl = 10'(c);
    base = c * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (table_q[base+w].tag == k[15:0]) begin
        a.found = table_q[base+w].depth != 0;
        a.mv = table_q[base+w].move;
        a.val = table_q[base+w].value;
        a.ev = table_q[base+w].eval;
        a.dep = 9'(int'(table_q[base+w].depth) + off);
        a.bnd = table_q[base+w].genbound[1:0];
        a.pvf = table_q[base+w].genbound[2];
        a.way = 2'(w);
        return a;
      end
    end
    best = 0;
    bestv = int'(table_q[base].depth) - 2 * int'(entry_age(table_q[base].genbound));
    for (int w = 1; w < WAYS; w++) begin
      v = int'(table_q[base+w].depth) - 2 * int'(entry_age(table_q[base+w].genbound));
      if (bestv > v) begin
        bestv = v;
        best = w;
      end
    end
    a.val = none_q;
    a.ev = none_q;
    a.dep = 9'(off);
    a.way = 2'(best);
    return a;
  endfunction

  task automatic write_entry();
    int i, d, off;
    logic tag_diff;
    if (int'(target_cluster) >= NUM_CLUSTERS || int'(target_way) >= WAYS) return;
    i = int'(target_cluster) * WAYS + int'(target_way);
    d = depth;
    off = $signed(doff_q);
    tag_diff = table_q[i].tag != key[15:0];
    if (best_move != 0 || tag_diff) table_q[i].move = best_move;
    if (bound == cht_pkg::BND_EXACT || tag_diff ||
        d - off + 2 * int'(pv) > int'(table_q[i].depth) - 4 ||
        entry_age(table_q[i].genbound) != 0) begin
      table_q[i].tag = key[15:0];
      table_q[i].depth = 8'(d - off);
      table_q[i].genbound = gen_q | {5'd0, pv, 2'd0} | {6'd0, bound};
      table_q[i].value = value;
      table_q[i].eval = eval;
    end
  endtask

  function automatic logic [9:0] fresh_permille(input logic [4:0] lim);
    longint cnt;
    cnt = 0;
    for (int i = 0; i < NSAMP * WAYS; i++)
      if (table_q[i].depth != 0 && entry_age(table_q[i].genbound) <= {lim, 3'd0}) cnt++;
    return 10'(cnt * cht_pkg::PERMILLE / (NSAMP * WAYS));
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    waiting = 0;
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst) begin
      for (int i = 0; i < NENT; i++) table_q[i] = '0;
      gen_q = '0;
      doff_q = cht_pkg::DOFF_RST;
      none_q = cht_pkg::NONE_RST;
      answers.delete();
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          report("unexpected done", 1, 0);
        end else begin
          a = answers.pop_front();
          if (found !== a.found) report("found", found, a.found);
          if (out_move !== a.mv) report("out_move", out_move, a.mv);
          if (out_value !== a.val) report("out_value", out_value, a.val);
          if (out_eval !== a.ev) report("out_eval", out_eval, a.ev);
          if (out_depth !== a.dep) report("out_depth", out_depth, a.dep);
          if (out_bound !== a.bnd) report("out_bound", out_bound, a.bnd);
          if (out_pv !== a.pvf) report("out_pv", out_pv, a.pvf);
          if (slot_cluster !== a.cl) report("slot_cluster", slot_cluster, a.cl);
          if (slot_way !== a.way) report("slot_way", slot_way, a.way);
          if (occupancy !== a.occ) report("occupancy", occupancy, a.occ);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cht_pkg::CFG_DOFF) doff_q = cfg_data[3:0];
        else if (cfg_index == cht_pkg::CFG_NONE) none_q = cfg_data;
      end
      if (start && !busy) begin
        a = '0;
        case (kind)
          cht_pkg::KIND_PROBE: a = lookup(key);
          cht_pkg::KIND_STORE: write_entry();
          cht_pkg::KIND_NEWS:  gen_q = gen_q + cht_pkg::GEN_STEP;
          cht_pkg::KIND_CLEAR: begin
            for (int i = 0; i < NENT; i++) table_q[i] = '0;
            gen_q = '0;
          end
          cht_pkg::KIND_OCC:   a.occ = fresh_permille(max_age);
          default: ;
        endcase
        answers.push_back(a);
      end
    end
    waiting = answers.size();
  end

endmodule

### test/clustered_hash_table_with_aging_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clustered_hash_table_with_aging_tb: stimulus for the clustered hash table
// Directed corner commands, then random probe/store traffic over a small key
// pool with new search, clear and occupancy mixed in, across several
// register settings and idle patterns. Checking lives in cht_checker.
// ----------------------------------------------------------------------------
module clustered_hash_table_with_aging_tb;

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
  localparam int         POOL = 24;

  logic clk, rst, start, busy;
  logic [2:0] kind;
  logic [63:0] key;
  logic signed [15:0] value, eval;
  logic signed [8:0] depth;
  logic [1:0] bound;
  logic pv;
  logic [15:0] best_move;
  logic [9:0] target_cluster;
  logic [1:0] target_way;
  logic [4:0] max_age;
  logic cfg_valid, cfg_ready;
  logic [cht_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic done, found, out_pv;
  logic [15:0] out_move;
  logic signed [15:0] out_value, out_eval;
  logic signed [8:0] out_depth;
  logic [1:0] out_bound, slot_way;
  logic [9:0] slot_cluster, occupancy;
  int fail_count, waiting;
  int idle_pct;
  logic [63:0] key_pool[POOL];

  clustered_hash_table_with_aging dut (.*);
  cht_checker scoreboard (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // one command beat; start stays high into the next beat unless a gap follows
  task automatic issue(input logic [2:0] k, input logic [63:0] kk, input logic [15:0] v,
                       input logic [15:0] e, input logic [8:0] d, input logic [1:0] b,
                       input logic p, input logic [15:0] mv, input logic [9:0] tc,
                       input logic [1:0] tw, input logic [4:0] ma);
    @(negedge clk);
    start = 1; kind = k; key = kk; value = v; eval = e; depth = d; bound = b; pv = p;
    best_move = mv; target_cluster = tc; target_way = tw; max_age = ma;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic store_to(input logic [63:0] kk, input logic [8:0] d, input logic [1:0] b,
                          input logic p, input logic [15:0] mv, input logic [1:0] tw);
    issue(cht_pkg::KIND_STORE, kk, 16'($urandom), 16'($urandom), d, b, p, mv, kk[63:54],
          tw, 5'($urandom));
  endtask

  task automatic probe(input logic [63:0] kk);
    issue(cht_pkg::KIND_PROBE, kk, 16'($urandom), 16'($urandom), 9'($urandom),
          2'($urandom), 1'($urandom), 16'($urandom), 10'($urandom), 2'($urandom),
          5'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cht_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_item();
    logic [63:0] kk;
    int r;
    kk = key_pool[$urandom_range(POOL - 1)];
    r = $urandom_range(999);
    if (r < 400) probe(kk);
    else if (r < 800) begin
      if ($urandom_range(19) == 0)
        issue(cht_pkg::KIND_STORE, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
              9'($urandom_range(262) - 7), 2'($urandom), 1'($urandom), 16'($urandom),
              10'($urandom), 2'($urandom), 5'($urandom));
      else
        store_to(kk, 9'($urandom_range(262) - 7), 2'($urandom), 1'($urandom),
                 ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), 2'($urandom_range(2)));
    end else if (r < 860)
      issue(cht_pkg::KIND_NEWS, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    else if (r < 870)
      issue(cht_pkg::KIND_CLEAR, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    else if (r < 910)
      issue(cht_pkg::KIND_OCC, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
            9'($urandom), 2'($urandom), 1'($urandom), 16'($urandom), 10'($urandom),
            2'($urandom), 5'($urandom));
    else if (r < 930)
      issue(3'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST)), {$urandom, $urandom},
            16'($urandom), 16'($urandom), 9'($urandom), 2'($urandom), 1'($urandom),
            16'($urandom), 10'($urandom), 2'($urandom), 5'($urandom));
    else probe({$urandom, $urandom});
  endtask

  initial begin
    logic [63:0] kk;
    rst = 1; start = 0; kind = cht_pkg::KIND_PROBE; key = 0; value = 0; eval = 0;
    depth = 0; bound = 0; pv = 0; best_move = 0; target_cluster = 0; target_way = 0;
    max_age = 0;
    cfg_valid = 0; cfg_index = cht_pkg::CFG_DOFF; cfg_data = 0;
    idle_pct = 0;
    // pool: a few clusters (both ends included), few tags so ways collide
    for (int i = 0; i < POOL; i++) begin
      case (i % 4)
        0: kk[63:54] = 10'd0;
        1: kk[63:54] = 10'd1023;
        default: kk[63:54] = 10'($urandom_range(2, 3));
      endcase
      kk[53:16] = {6'($urandom), $urandom};
      kk[15:0] = 16'($urandom_range(4)) * 16'h1111;
      key_pool[i] = kk;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners at reset settings
    probe(key_pool[0]);
    store_to(key_pool[0], 9'd255, cht_pkg::BND_EXACT, 1, 16'hFFFF, 0);
    store_to(key_pool[4], -9'sd7, 2'd1, 0, 16'h0001, 1);
    probe(key_pool[0]);
    probe(key_pool[4]);
    store_to(key_pool[0], 9'd3, 2'd2, 0, 16'd0, 0);
    store_to(key_pool[0], 9'd200, 2'd2, 1, 16'd0, 0);
    store_to(key_pool[1], 9'd100, cht_pkg::BND_EXACT, 1, 16'h8000, 2);
    issue(cht_pkg::KIND_STORE, key_pool[1], 16'h7FFF, 16'h8000, 9'd50, 2'd1, 0, 16'h1234,
          10'd1023, 2'd3, 0);
    probe(key_pool[1]);
    probe(64'hFFFF_FFFF_FFFF_FFFF);
    issue(cht_pkg::KIND_OCC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5'd0);
    issue(cht_pkg::KIND_NEWS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    store_to(key_pool[0], 9'd1, 2'd0, 0, 16'd0, 0);
    issue(cht_pkg::KIND_OCC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5'd31);
    issue(cht_pkg::KIND_OCC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5'd0);
    probe(key_pool[8]);
    issue(KIND_RSVD_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 2'd3, 1,
          16'hFFFF, 10'h3FF, 2'd3, 5'h1F);
    issue(cht_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    probe(key_pool[0]);
    drain();

    // extreme offset: depth wraps on store and on read
    write_reg(cht_pkg::CFG_DOFF, 16'hFFF8);
    write_reg(cht_pkg::CFG_NONE, 16'h8000);
    store_to(key_pool[2], 9'd255, cht_pkg::BND_EXACT, 1, 16'h00FF, 0);
    probe(key_pool[2]);
    probe(key_pool[6]);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 50 : 0;
      for (int n = 0; n < 250; n++) random_item();
      drain();
      if (phase == 0) begin
        write_reg(cht_pkg::CFG_DOFF, 16'h0000);
        write_reg(cht_pkg::CFG_NONE, 16'h7FFF);
      end else if (phase == 1) begin
        write_reg(cht_pkg::CFG_DOFF, {12'($urandom), 4'($urandom_range(8) + 8)});
        write_reg(cht_pkg::CFG_NONE, 16'($urandom));
      end
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
